// File: design/assert_macros.svh
// Assertion macros shared by the half-step sequencer RTL.
// Included by files that carry concurrent assertions; empty under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked assertion, disabled while reset is active
`define HSS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion, also checked during reset
`define HSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define HSS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: design/hss_pkg.sv
// Package for the half-step sequencer: field widths, request codes, coil table.
// No dependencies; used by the channel interfaces and the core.
`timescale 1ns / 1ps

package hss_pkg;

  localparam int unsigned CountW = 17;
  localparam int unsigned PosW   = 16;
  localparam int unsigned CoilW  = 4;

  localparam logic [PosW-1:0] RevReset = 16'd4096;

  // Request kinds
  localparam logic REQ_MOVE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef logic [CoilW-1:0] coil_t;
  typedef logic [PosW-1:0]  pos_t;

  // Half-step coil pattern for position mod 8
  function automatic coil_t half_step(input logic [2:0] idx);
    coil_t pat;
    case (idx)
      3'd0:    pat = 4'b0001;
      3'd1:    pat = 4'b0011;
      3'd2:    pat = 4'b0010;
      3'd3:    pat = 4'b0110;
      3'd4:    pat = 4'b0100;
      3'd5:    pat = 4'b1100;
      3'd6:    pat = 4'b1000;
      3'd7:    pat = 4'b1001;
      default: pat = 4'b0000;
    endcase
    return pat;
  endfunction

endpackage

// File: design/hss_if.sv
// Valid/ready channel interfaces for the sequencer request and result items.
// Depends on hss_pkg for field widths.
`timescale 1ns / 1ps

interface hss_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic signed [hss_pkg::CountW-1:0] step_count;

  modport source (output valid, output req_type, output step_count, input ready);
  modport sink   (input valid, input req_type, input step_count, output ready);
endinterface

interface hss_res_if;
  logic                valid;
  logic                ready;
  hss_pkg::coil_t      coils;
  hss_pkg::pos_t       position;
  hss_pkg::pos_t       steps_remaining;
  logic                running;

  modport source (output valid, output coils, output position,
                  output steps_remaining, output running, input ready);
  modport sink   (input valid, input coils, input position,
                  input steps_remaining, input running, output ready);
endinterface

// File: design/stepper_half_step_sequencer_core.sv
// Half-step stepper sequencer core: one request item in, one result item out.
// Result valid in the cycle after request accept (registered); throughput: one item
// per cycle unless stalled, set by the single state update feeding the result register.
// A held result stalls input only while out_ch.ready is low.
// Reset (rst_n low, synchronous): idle, position 0, reverse, coils off, 4096 steps/rev.
// Depends on hss_pkg, hss_if.sv and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stepper_half_step_sequencer_core (
  input  logic                       clk,
  input  logic                       rst_n,
  hss_req_if.sink                    in_ch,
  hss_res_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [hss_pkg::PosW-1:0]   cfg_wdata
);

  // Architectural state
  hss_pkg::pos_t  spr_r, spr_nxt;
  hss_pkg::pos_t  rem_r, rem_nxt;
  hss_pkg::pos_t  pos_r, pos_nxt;
  logic           fwd_r, fwd_nxt;
  logic           busy_r, busy_nxt;
  hss_pkg::coil_t coil_r, coil_nxt;

  // Result register
  logic           ovalid_r;
  hss_pkg::coil_t ocoil_r;
  hss_pkg::pos_t  opos_r;
  hss_pkg::pos_t  orem_r;
  logic           orun_r;

  logic in_acc;
  assign in_ch.ready = !ovalid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Move command decode: magnitude with saturation of the largest negative count
  logic [hss_pkg::CountW-1:0] raw, mag_full;
  logic                       neg;
  hss_pkg::pos_t              mag;
  assign raw      = in_ch.step_count;
  assign neg      = raw[hss_pkg::CountW-1];
  assign mag_full = neg ? (~raw + 17'd1) : raw;
  assign mag      = mag_full[hss_pkg::CountW-1] ? 16'hFFFF : mag_full[hss_pkg::PosW-1:0];

  // Position step with wrap; zero steps/rev means a full 16-bit span
  logic [hss_pkg::PosW:0] span, fwd_sum, span_m1;
  hss_pkg::pos_t          step_pos, rem_dec;
  assign span     = (spr_r == '0) ? 17'h10000 : {1'b0, spr_r};
  assign fwd_sum  = {1'b0, pos_r} + 17'd1;
  assign span_m1  = span - 17'd1;
  assign rem_dec  = rem_r - 16'd1;
  always_comb begin
    if (fwd_r) begin
      step_pos = (fwd_sum >= span) ? '0 : fwd_sum[hss_pkg::PosW-1:0];
    end else if (pos_r == '0) begin
      step_pos = span_m1[hss_pkg::PosW-1:0];
    end else begin
      step_pos = pos_r - 16'd1;
    end
  end

  // Next state for one accepted item
  always_comb begin
    spr_nxt  = cfg_we ? cfg_wdata : spr_r;
    rem_nxt  = rem_r;
    pos_nxt  = pos_r;
    fwd_nxt  = fwd_r;
    busy_nxt = busy_r;
    coil_nxt = coil_r;
    if (in_acc) begin
      if (in_ch.req_type == hss_pkg::REQ_MOVE) begin
        if (raw != '0) begin
          fwd_nxt = !neg;
        end
        rem_nxt = mag;
        if (mag == '0) begin
          busy_nxt = 1'b0;
          coil_nxt = '0;
        end else begin
          busy_nxt = 1'b1;
        end
      end else if (busy_r) begin
        rem_nxt = rem_dec;
        pos_nxt = step_pos;
        if (rem_dec == '0) begin
          coil_nxt = '0;
          busy_nxt = 1'b0;
        end else begin
          coil_nxt = hss_pkg::half_step(step_pos[2:0]);
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_r  <= hss_pkg::RevReset;
      rem_r  <= '0;
      pos_r  <= '0;
      fwd_r  <= 1'b0;
      busy_r <= 1'b0;
      coil_r <= '0;
    end else begin
      spr_r  <= spr_nxt;
      rem_r  <= rem_nxt;
      pos_r  <= pos_nxt;
      fwd_r  <= fwd_nxt;
      busy_r <= busy_nxt;
      coil_r <= coil_nxt;
    end
  end

  // Result register: loads the post-item state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (in_acc) begin
      ovalid_r <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ocoil_r <= coil_nxt;
      opos_r  <= pos_nxt;
      orem_r  <= rem_nxt;
      orun_r  <= busy_nxt;
    end
  end

  assign out_ch.valid           = ovalid_r;
  assign out_ch.coils           = ocoil_r;
  assign out_ch.position        = opos_r;
  assign out_ch.steps_remaining = orem_r;
  assign out_ch.running         = orun_r;

  // Checks
  `HSS_ASSERT(a_idle_coils_off, clk, rst_n, !busy_r |-> coil_r == '0, "coils on while idle")
  `HSS_ASSERT(a_busy_has_steps, clk, rst_n, busy_r |-> rem_r != '0, "busy with no steps left")
  `HSS_ASSERT(a_tick_decrements, clk, rst_n, (in_acc && in_ch.req_type == hss_pkg::REQ_TICK && busy_r) |=> (rem_r == $past(rem_dec)), "tick did not consume a step")
  `HSS_ASSERT(a_result_matches, clk, rst_n, in_acc |=> (orun_r == busy_r && orem_r == rem_r), "result differs from state")

endmodule

// File: bench/sequencer_checker.sv
// Scoreboard for the half-step sequencer: watches the request, result and register ports,
// predicts every result item and compares it field by field. Depends on hss_pkg and hss_if.sv.
`timescale 1ns / 1ps

module sequencer_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  hss_req_if                       req,
  hss_res_if                       res,
  input  logic                     cfg_we,
  input  logic [hss_pkg::PosW-1:0] cfg_wdata,
  output int                       fail_count,
  output int                       pending,
  output int                       results_seen
);

  typedef struct packed {
    hss_pkg::coil_t coils;
    hss_pkg::pos_t  position;
    hss_pkg::pos_t  steps_remaining;
    logic           running;
  } motor_state_t;

  // Predicted motor state
  hss_pkg::pos_t  rev_span;
  hss_pkg::pos_t  steps_todo;
  logic           going_fwd;
  hss_pkg::pos_t  cur_pos;
  logic           moving;
  hss_pkg::coil_t drive;

  motor_state_t motor_q[$];

  // Coil drive for one position within the eight-phase half-step cycle
  function automatic hss_pkg::coil_t phase_coils(input logic [2:0] phase);
    case (phase)
      3'd0:    return 4'b0001;
      3'd1:    return 4'b0011;
      3'd2:    return 4'b0010;
      3'd3:    return 4'b0110;
      3'd4:    return 4'b0100;
      3'd5:    return 4'b1100;
      3'd6:    return 4'b1000;
      default: return 4'b1001;
    endcase
  endfunction

  // Apply one request to the predicted state and return the state it reports
  task automatic apply_request(input logic kind,
                               input logic signed [hss_pkg::CountW-1:0] cnt,
                               output motor_state_t rep);
    int span;
    int mag;
    int nxt;
    if (kind == hss_pkg::REQ_MOVE) begin
      mag = (cnt < 0) ? -int'(cnt) : int'(cnt);
      // -65536 has no 16-bit magnitude: saturate
      if (mag > 65535) mag = 65535;
      if (cnt != 0) going_fwd = (cnt > 0);
      steps_todo = hss_pkg::pos_t'(mag);
      if (mag == 0) begin
        moving = 1'b0;
        drive  = '0;
      end else begin
        moving = 1'b1;
      end
    end else if (moving) begin
      steps_todo = steps_todo - 1'b1;
      // zero span register means a full 16-bit revolution
      span = (rev_span == 0) ? 65536 : int'(rev_span);
      if (going_fwd) begin
        nxt = int'(cur_pos) + 1;
        cur_pos = (nxt >= span) ? '0 : hss_pkg::pos_t'(nxt);
      end else begin
        cur_pos = (cur_pos == 0) ? hss_pkg::pos_t'(span - 1) : cur_pos - 1'b1;
      end
      if (steps_todo == 0) begin
        drive  = '0;
        moving = 1'b0;
      end else begin
        drive = phase_coils(cur_pos[2:0]);
      end
    end
    rep = '{coils: drive, position: cur_pos, steps_remaining: steps_todo,
            running: moving};
  endtask

  always @(posedge clk) begin
    motor_state_t pred;
    motor_state_t want;
    motor_state_t got;
    if (!rst_n) begin
      rev_span     = hss_pkg::RevReset;
      steps_todo   = '0;
      going_fwd    = 1'b0;
      cur_pos      = '0;
      moving       = 1'b0;
      drive        = '0;
      motor_q.delete();
      fail_count   = 0;
      pending      = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) rev_span = cfg_wdata;

      // predict first so that a same-cycle result would still find its entry
      if (req.valid && req.ready) begin
        apply_request(req.req_type, req.step_count, pred);
        motor_q.push_back(pred);
      end

      if (res.valid && res.ready) begin
        got = '{coils: res.coils, position: res.position,
                steps_remaining: res.steps_remaining, running: res.running};
        results_seen++;
        if (motor_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] result item with nothing outstanding: %s=%b pos=%0d rem=%0d run=%0b",
                     $realtime, "coils", got.coils, got.position, got.steps_remaining,
                     got.running);
        end else begin
          want = motor_q.pop_front();
          if (got.coils !== want.coils || got.position !== want.position ||
              got.steps_remaining !== want.steps_remaining || got.running !== want.running) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("[%0t] mismatch: exp coils=%b pos=%0d rem=%0d run=%0b",
                       $realtime, want.coils, want.position, want.steps_remaining,
                       want.running);
              $display("           got coils=%b pos=%0d rem=%0d run=%0b",
                       got.coils, got.position, got.steps_remaining, got.running);
            end
          end
        end
      end
      pending = motor_q.size();
    end
  end

endmodule

// File: bench/testbench.sv
// Top of the half-step sequencer bench: clock, reset, request and register stimulus,
// result back-pressure, watchdog and verdict. Depends on hss_pkg, hss_if.sv and sequencer_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int StallLimit = 2000;

  typedef logic signed [hss_pkg::CountW-1:0] count_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [hss_pkg::PosW-1:0] cfg_wdata;

  bit sender_gaps;
  bit sink_stalls;

  int fail_count;
  int pending;
  int results_seen;
  int moves_sent;
  int ticks_sent;
  int revs_written;

  hss_req_if in_ch ();
  hss_res_if out_ch ();

  stepper_half_step_sequencer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  sequencer_checker seq_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (in_ch),
    .res          (out_ch),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result back-pressure: random stall bursts while sink_stalls is set
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_stalls && hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 16) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        hold = 0;
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no item moves for too long
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Watchdog: no item moved for %0d cycles, %0d results outstanding",
             StallLimit, pending);
    $display("Verification failed");
    $finish;
  end

  // Send one request item, with an optional gap before it
  task automatic issue_request(input logic kind, input count_t cnt);
    int gap;
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= kind;
    in_ch.step_count <= cnt;
    do @(posedge clk); while (!in_ch.ready);
    if (kind == hss_pkg::REQ_MOVE) moves_sent++;
    else ticks_sent++;
  endtask

  // Drain all results, then write the steps-per-revolution register
  task automatic program_rev(input logic [hss_pkg::PosW-1:0] span);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= span;
    @(negedge clk);
    cfg_we <= 1'b0;
    revs_written++;
  endtask

  task automatic tick_n(input int n);
    repeat (n) issue_request(hss_pkg::REQ_TICK, '0);
  endtask

  // Random traffic: mostly a move followed by its ticks, plus stops, noise and stray ticks
  task automatic random_traffic(input int budget);
    int work;
    int n;
    int nticks;
    int pick;
    count_t cnt;
    work = 0;
    while (work < budget) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
        cnt = count_t'(($urandom_range(0, 1) != 0) ? -n : n);
        issue_request(hss_pkg::REQ_MOVE, cnt);
        work++;
        // some moves are cut short by the next command, some overrun into idle ticks
        nticks = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1)
                                             : n + $urandom_range(0, 2);
        for (int t = 0; t < nticks; t++) begin
          issue_request(hss_pkg::REQ_TICK, count_t'($urandom));
          if (t < n) work++;
        end
      end else if (pick == 7) begin
        issue_request(hss_pkg::REQ_MOVE, '0);
        work++;
      end else if (pick == 8) begin
        issue_request(hss_pkg::REQ_MOVE, count_t'($urandom));
        nticks = $urandom_range(0, 5);
        tick_n(nticks);
        work += 1 + nticks;
      end else begin
        repeat ($urandom_range(1, 3)) issue_request(hss_pkg::REQ_TICK, count_t'($urandom));
      end
    end
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.req_type   = hss_pkg::REQ_MOVE;
    in_ch.step_count = '0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    sender_gaps      = 1'b1;
    sink_stalls      = 1'b1;
    moves_sent       = 0;
    ticks_sent       = 0;
    revs_written     = 0;
    rst_n            = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: idle tick, stop while idle, short forward and reverse moves
    issue_request(hss_pkg::REQ_TICK, '0);
    issue_request(hss_pkg::REQ_MOVE, '0);
    issue_request(hss_pkg::REQ_MOVE, 17'sd3);
    tick_n(4);
    issue_request(hss_pkg::REQ_MOVE, -17'sd2);
    tick_n(3);
    // most negative count saturates, then a stop mid-move
    issue_request(hss_pkg::REQ_MOVE, 17'sh10000);
    issue_request(hss_pkg::REQ_TICK, '0);
    issue_request(hss_pkg::REQ_MOVE, '0);
    issue_request(hss_pkg::REQ_TICK, '0);
    // largest forward count, replaced while running, then stop keeps direction
    issue_request(hss_pkg::REQ_MOVE, 17'sd65535);
    issue_request(hss_pkg::REQ_TICK, '0);
    issue_request(hss_pkg::REQ_MOVE, -17'sd65535);
    issue_request(hss_pkg::REQ_TICK, '0);
    issue_request(hss_pkg::REQ_MOVE, 17'sd7);
    issue_request(hss_pkg::REQ_TICK, '0);
    issue_request(hss_pkg::REQ_MOVE, '0);

    // Short revolutions: forward wraps to zero, reverse at zero wraps to the last position
    program_rev(16'd3);
    issue_request(hss_pkg::REQ_MOVE, 17'sd2);
    tick_n(2);
    program_rev(16'd1);
    issue_request(hss_pkg::REQ_MOVE, -17'sd3);
    tick_n(3);

    // Random phases over a range of revolution sizes, extremes included
    program_rev(16'd8);
    random_traffic(55);
    program_rev(16'd1);
    random_traffic(55);
    program_rev(16'd2);
    random_traffic(55);
    program_rev(16'd65535);
    random_traffic(55);
    program_rev(16'd0);
    random_traffic(55);
    program_rev(16'($urandom_range(3, 65534)));
    random_traffic(55);
    program_rev(16'd5);
    random_traffic(55);
    program_rev(hss_pkg::RevReset);
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    random_traffic(55);

    // Drain and allow a few cycles for any stray result
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);

    $display("Sent %0d move and %0d tick items across %0d revolution settings;",
             moves_sent, ticks_sent, revs_written);
    $display("checked %0d result items, %0d mismatched, %0d outstanding.",
             results_seen, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: stepper_half_step_sequencer_core.f
+incdir+design
design/hss_pkg.sv
design/hss_if.sv
design/stepper_half_step_sequencer_core.sv
bench/sequencer_checker.sv
bench/testbench.sv
